// File: hw/rtl/glos_pkg.sv
`timescale 1ns / 1ps

package glos_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned DELTA_W = COORD_W + 1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic load;
    logic wr_en;
    logic clr_run;
    logic div_start;
    logic div_run;
    logic walk_start;
    logic walk_run;
  } glos_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic present;
    logic same;
    logic div_last;
    logic hit;
    logic fin;
  } glos_sts_t;

endpackage

// File: hw/rtl/grid_line_of_sight.sv
`timescale 1ns / 1ps
// A query runs the bit-serial divider for the minor step, then walks the line with one grid
// memory read per walk step.
// No target or identical points: strobe from S_PREP without divide or walk; a write passes S_WRITE.
// The next request is taken in the cycle of the result strobe; the receiver cannot stall.
// After reset the block clears all MAP_SIDE * MAP_SIDE grid cells, one cell a cycle, busy high.

module grid_line_of_sight #(
  parameter int unsigned MAP_SIDE      = 256,
  parameter int unsigned CELL_SHIFT    = 4,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [glos_pkg::COORD_W-1:0] source_x_i,
  input  logic [glos_pkg::COORD_W-1:0] source_y_i,
  input  logic [glos_pkg::COORD_W-1:0] target_x_i,
  input  logic [glos_pkg::COORD_W-1:0] target_y_i,
  input  logic                         target_present_i,
  input  logic                         cell_blocked_i,
  output logic                         result_valid_o,
  output logic                         in_sight_o
);

  import glos_pkg::*;

  glos_cmd_t cmd;
  glos_sts_t sts;

  glos_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .command_i      (command_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .in_sight_o     (in_sight_o)
  );

  glos_dp #(
    .MAP_SIDE      (MAP_SIDE),
    .CELL_SHIFT    (CELL_SHIFT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .source_x_i       (source_x_i),
    .source_y_i       (source_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .target_present_i (target_present_i),
    .cell_blocked_i   (cell_blocked_i)
  );

  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("Result strobe while busy.");

  a_request_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Request accepted but busy did not rise.");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Result strobe lasted more than one cycle.");

  a_walk_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.hit && cmd.walk_run) |=> (result_valid_o && !in_sight_o))
    else $error("Blocked cell during walk did not give a blocked result.");

endmodule

// File: hw/rtl/glos_ram.sv
`timescale 1ns / 1ps

module glos_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/glos_ctrl.sv
`timescale 1ns / 1ps

module glos_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                command_i,
  input  glos_pkg::glos_sts_t sts_i,
  output glos_pkg::glos_cmd_t cmd_o,
  output logic                busy_o,
  output logic                result_valid_o,
  output logic                in_sight_o
);

  import glos_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_PREP,
    S_DIV,
    S_INIT,
    S_WALK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   valid_q, valid_d;
  logic   sight_q, sight_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    valid_d = 1'b0;
    sight_d = sight_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = (command_i == CMD_QUERY) ? S_PREP : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = S_IDLE;
        busy_d      = 1'b0;
      end
      S_PREP: begin
        if (!sts_i.present || sts_i.same) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
          valid_d = 1'b1;
          sight_d = sts_i.present;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.walk_start = 1'b1;
        state_d          = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (sts_i.hit || sts_i.fin) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
          valid_d = 1'b1;
          sight_d = !sts_i.hit;
        end
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
      sight_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      valid_q <= valid_d;
      sight_q <= sight_d;
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = valid_q;
  assign in_sight_o     = sight_q;

endmodule

// File: hw/rtl/glos_dp.sv
`timescale 1ns / 1ps

module glos_dp #(
  parameter int unsigned MAP_SIDE      = 256,
  parameter int unsigned CELL_SHIFT    = 4,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  glos_pkg::glos_cmd_t          cmd_i,
  output glos_pkg::glos_sts_t          sts_o,
  input  logic [glos_pkg::COORD_W-1:0] source_x_i,
  input  logic [glos_pkg::COORD_W-1:0] source_y_i,
  input  logic [glos_pkg::COORD_W-1:0] target_x_i,
  input  logic [glos_pkg::COORD_W-1:0] target_y_i,
  input  logic                         target_present_i,
  input  logic                         cell_blocked_i
);

  import glos_pkg::*;

  localparam int unsigned DEPTH  = MAP_SIDE * MAP_SIDE;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned POS_W  = FRACTION_BITS + 14;
  localparam int unsigned DIV_W  = FRACTION_BITS + DELTA_W;
  localparam int unsigned DCNT_W = $clog2(DIV_W);
  localparam logic [DELTA_W-1:0] SIDE_C = DELTA_W'(MAP_SIDE);
  localparam logic [POS_W-1:0]   ONE_POS =
    {{(POS_W-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DELTA_W-1:0] cx,
                                                  input logic [DELTA_W-1:0] cy);
    return ADDR_W'(cy) * ADDR_W'(MAP_SIDE) + ADDR_W'(cx);
  endfunction

  // A position just below zero truncates to world coordinate zero.
  function automatic logic pos_ok(input logic [POS_W-1:0] p);
    return !p[POS_W-1] || ((&p[POS_W-2:FRACTION_BITS]) && (|p[FRACTION_BITS-1:0]));
  endfunction

  function automatic logic [DELTA_W-1:0] pos_cell(input logic [POS_W-1:0] p);
    logic [DELTA_W-1:0] world;
    world = p[POS_W-1] ? '0 : p[POS_W-2:FRACTION_BITS];
    return world >> CELL_SHIFT;
  endfunction

  logic [COORD_W-1:0] sx_q, sy_q, tx_q, ty_q;
  logic               present_q, blk_q;

  logic [ADDR_W-1:0]  clr_q;

  logic [COORD_W-1:0] major_q;
  logic               x_major_q, neg_maj_q, neg_min_q;
  logic [COORD_W-1:0] rem_q;
  logic [DIV_W-1:0]   dvd_q;
  logic [DCNT_W-1:0]  dcnt_q;

  logic [POS_W-1:0]   pos_x_q, pos_y_q, step_x_q, step_y_q;
  logic [COORD_W-1:0] cnt_q;
  logic               a_vld_q, a_last_q, b_vld_q, b_last_q, b_inmap_q;

  logic [DELTA_W-1:0] dx, dy;
  logic [COORD_W-1:0] ax, ay, major_c, mag_c;
  logic               x_major_c;
  logic [DIV_W-1:0]   dvd_init;

  logic [DELTA_W-1:0] tmp;
  logic               ge;

  logic [POS_W-1:0]   quot, step_maj, step_min;

  logic [DELTA_W-1:0] wcx, wcy, rcx, rcy;
  logic               w_inmap, r_inmap;
  logic               issue;

  logic               ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;

  always_comb begin
    dx        = {1'b0, tx_q} - {1'b0, sx_q};
    dy        = {1'b0, ty_q} - {1'b0, sy_q};
    ax        = dx[DELTA_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
    ay        = dy[DELTA_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    x_major_c = ax > ay;
    major_c   = x_major_c ? ax : ay;
    mag_c     = x_major_c ? ay : ax;
    dvd_init  = {1'b0, mag_c, {FRACTION_BITS{1'b0}}} + DIV_W'(major_c >> 1);
  end

  assign tmp = {rem_q, dvd_q[DIV_W-1]};
  assign ge  = tmp >= {1'b0, major_q};

  always_comb begin
    quot     = POS_W'(dvd_q[FRACTION_BITS:0]);
    step_maj = neg_maj_q ? -ONE_POS : ONE_POS;
    step_min = neg_min_q ? -quot : quot;
  end

  assign wcx     = {1'b0, sx_q} >> CELL_SHIFT;
  assign wcy     = {1'b0, sy_q} >> CELL_SHIFT;
  assign w_inmap = (wcx < SIDE_C) && (wcy < SIDE_C);

  assign rcx     = pos_cell(pos_x_q);
  assign rcy     = pos_cell(pos_y_q);
  assign r_inmap = pos_ok(pos_x_q) && pos_ok(pos_y_q) && (rcx < SIDE_C) && (rcy < SIDE_C);

  assign issue = cmd_i.walk_run && (cnt_q != major_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_run) begin
        clr_q <= clr_q + 1'b1;
      end
      a_vld_q <= issue;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q      <= source_x_i;
      sy_q      <= source_y_i;
      tx_q      <= target_x_i;
      ty_q      <= target_y_i;
      present_q <= target_present_i;
      blk_q     <= cell_blocked_i;
    end
    if (cmd_i.div_start) begin
      major_q   <= major_c;
      x_major_q <= x_major_c;
      neg_maj_q <= x_major_c ? dx[DELTA_W-1] : dy[DELTA_W-1];
      neg_min_q <= x_major_c ? dy[DELTA_W-1] : dx[DELTA_W-1];
      rem_q     <= '0;
      dvd_q     <= dvd_init;
      dcnt_q    <= '0;
    end else if (cmd_i.div_run) begin
      rem_q  <= ge ? COORD_W'(tmp - {1'b0, major_q}) : COORD_W'(tmp);
      dvd_q  <= {dvd_q[DIV_W-2:0], ge};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.walk_start) begin
      pos_x_q  <= POS_W'({sx_q, {FRACTION_BITS{1'b0}}});
      pos_y_q  <= POS_W'({sy_q, {FRACTION_BITS{1'b0}}});
      step_x_q <= x_major_q ? step_maj : step_min;
      step_y_q <= x_major_q ? step_min : step_maj;
      cnt_q    <= '0;
    end else if (issue) begin
      pos_x_q <= pos_x_q + step_x_q;
      pos_y_q <= pos_y_q + step_y_q;
      cnt_q   <= cnt_q + 1'b1;
    end
    a_last_q  <= ({1'b0, cnt_q} + 1'b1) == {1'b0, major_q};
    b_last_q  <= a_last_q;
    b_inmap_q <= r_inmap;
  end

  always_comb begin
    ram_we    = cmd_i.clr_run || (cmd_i.wr_en && w_inmap);
    ram_waddr = cmd_i.clr_run ? clr_q : cell_addr(wcx, wcy);
    ram_wdata = cmd_i.clr_run ? 1'b0 : blk_q;
    ram_raddr = cell_addr(rcx, rcy);
  end

  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (a_vld_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    sts_o          = '0;
    sts_o.clr_last = clr_q == ADDR_W'(DEPTH - 1);
    sts_o.present  = present_q;
    sts_o.same     = (sx_q == tx_q) && (sy_q == ty_q);
    sts_o.div_last = dcnt_q == DCNT_W'(DIV_W - 1);
    sts_o.hit      = b_vld_q && b_inmap_q && ram_rdata;
    sts_o.fin      = b_vld_q && b_last_q;
  end

endmodule
